/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the LED bar sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/lbps_pkg.sv */
// Types and constants of the LED bar pattern sequencer
`default_nettype none
package lbps_pkg;

    localparam int NUM_PIXELS = 15;
    localparam int PIX_IDX_W  = $clog2(NUM_PIXELS);
    localparam int PIXEL_W    = 32;
    localparam int IDX_OUT_W  = 6;
    localparam int OP_W       = 2;
    localparam int PAT_W      = 3;
    localparam int POS_W      = 8;
    localparam int ACC_W      = 17;
    localparam int INTERVAL_W = 16;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACC_W-1:0]      TICK_AMOUNT  = ACC_W'(4 * 256);
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL = INTERVAL_W'(4 * 256);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } lbps_op_t;

    typedef enum logic [PAT_W-1:0] {
        PAT_CHASE      = 3'd0,
        PAT_FILL       = 3'd1,
        PAT_DRAIN      = 3'd2,
        PAT_DRAIN_FILL = 3'd3,
        PAT_OVERHEAT   = 3'd4,
        PAT_STARTUP    = 3'd5
    } lbps_pat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN  = 2'd0,
        REG_COLOR    = 2'd1,
        REG_INTERVAL = 2'd2,
        REG_LIMIT    = 2'd3
    } lbps_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_STATUS
    } lbps_state_t;

    typedef logic [PIXEL_W-1:0] lbps_strip_t [NUM_PIXELS];

    typedef struct packed {
        logic exec;
        logic advance;
    } lbps_ctl_t;

    typedef struct packed {
        logic emit_frame;
        logic last_pixel;
    } lbps_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/lbps_cmd_if.sv */
// Command channel: operation word into the sequencer
`default_nettype none
interface lbps_cmd_if;
    import lbps_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic            clear_on_stop;

    modport source (output valid, operation, clear_on_stop, input ready);
    modport sink   (input valid, operation, clear_on_stop, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lbps_pix_if.sv */
// Pixel channel: result words out of the sequencer
`default_nettype none
interface lbps_pix_if;
    import lbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 frame_valid;
    logic [IDX_OUT_W-1:0] pixel_index;
    logic [PIXEL_W-1:0]   pixel_word;
    logic                 last_pixel;
    logic                 is_running;
    logic                 pattern_finished;

    modport source (output valid, frame_valid, pixel_index, pixel_word, last_pixel,
                    is_running, pattern_finished, input ready);
    modport sink   (input valid, frame_valid, pixel_index, pixel_word, last_pixel,
                    is_running, pattern_finished, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lbps_datapath.sv */
// Datapath: config registers, strip store, pattern steps and pixel streaming
`default_nettype none
`include "assert_macros.svh"
module lbps_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lbps_pkg::lbps_ctl_t               ctl,
    output lbps_pkg::lbps_stat_t              stat,
    input  logic [lbps_pkg::OP_W-1:0]         operation,
    input  logic                              clear_on_stop,
    input  logic                              cfg_write,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              frame_valid,
    output logic [lbps_pkg::IDX_OUT_W-1:0]    pixel_index,
    output logic [lbps_pkg::PIXEL_W-1:0]      pixel_word,
    output logic                              last_pixel,
    output logic                              is_running,
    output logic                              pattern_finished
);
    import lbps_pkg::*;

    localparam logic [POS_W-1:0]     PN_POS   = POS_W'(NUM_PIXELS);
    localparam logic [POS_W-1:0]     LAST_POS = POS_W'(NUM_PIXELS - 1);
    localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(NUM_PIXELS - 1);

    logic [PAT_W-1:0]      pattern_reg;
    logic [PIXEL_W-1:0]    color_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    lbps_strip_t           strip_reg, strip_next, strip_exec, pat_strip;
    logic [NUM_PIXELS-1:0] nz_reg, nz_next, nz_exec, pat_nz;
    logic [POS_W-1:0]      step_reg, step_next, pat_step;
    logic [POS_W-1:0]      drop_reg, drop_next, pat_drop;
    logic [ACC_W-1:0]      acc_reg, acc_next, acc_sum, interval;
    logic [LIMIT_W-1:0]    steps_reg, steps_next;
    logic                  first_reg, first_next;
    logic                  running_reg, running_next;
    logic                  finished_reg, finished_next;
    logic                  frame_valid_reg;
    logic [PIX_IDX_W-1:0]  idx_reg;

    logic                  emit_frame, run_pat, timed, pat_done, lit_nz;
    logic [POS_W-1:0]      sp, dp, step_inc, drop_inc;
    logic [PIX_IDX_W-1:0]  wr_idx, below_idx, above_idx;
    logic [PIXEL_W-1:0]    moved;
    logic                  moved_nz, off;

    assign lit_nz = |color_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            color_reg    <= '0;
            interval_reg <= MIN_INTERVAL;
            limit_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (lbps_reg_t'(cfg_index))
                REG_PATTERN:  pattern_reg  <= cfg_data[PAT_W-1:0];
                REG_COLOR:    color_reg    <= cfg_data[PIXEL_W-1:0];
                REG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_LIMIT:    limit_reg    <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // one pattern step; initial form while first_reg is set
    always_comb
    begin
        pat_strip = strip_reg;
        pat_nz    = nz_reg;
        pat_step  = step_reg;
        pat_drop  = drop_reg;
        pat_done  = 1'b0;
        sp        = step_reg;
        dp        = drop_reg;
        step_inc  = '0;
        drop_inc  = '0;
        wr_idx    = '0;
        below_idx = '0;
        above_idx = '0;
        moved     = '0;
        moved_nz  = 1'b0;
        off       = ~nz_reg[0];
        case (pattern_reg)
            PAT_CHASE:
            begin
                if (first_reg || step_reg >= PN_POS)
                begin
                    pat_strip = '{default: '0};
                    pat_nz    = '0;
                    sp        = first_reg ? POS_W'(1) : '0;
                end
                else
                begin
                    sp = step_reg + 1'b1;
                end
                wr_idx = PIX_IDX_W'(sp - 1'b1);
                if (sp != '0)
                begin
                    for (int i = 0; i < NUM_PIXELS; i++)
                    begin
                        if (i == int'(wr_idx))
                        begin
                            pat_strip[i] = color_reg;
                            pat_nz[i]    = lit_nz;
                        end
                    end
                end
                pat_step = sp;
            end
            PAT_FILL:
            begin
                sp       = first_reg ? '0 : step_reg;
                wr_idx   = (sp >= PN_POS) ? PIX_IDX_W'(sp - PN_POS) : PIX_IDX_W'(sp);
                for (int i = 0; i < NUM_PIXELS; i++)
                begin
                    if (i == int'(wr_idx))
                    begin
                        pat_strip[i] = color_reg;
                        pat_nz[i]    = lit_nz;
                    end
                end
                step_inc = sp + 1'b1;
                pat_done = (step_inc >= PN_POS);
                pat_step = pat_done ? '0 : step_inc;
            end
            PAT_DRAIN, PAT_DRAIN_FILL:
            begin
                if (pattern_reg == PAT_DRAIN_FILL && first_reg)
                begin
                    pat_strip = '{default: color_reg};
                    pat_nz    = {NUM_PIXELS{lit_nz}};
                end
                else
                begin
                    for (int i = 0; i < NUM_PIXELS - 1; i++)
                    begin
                        pat_strip[i] = strip_reg[i + 1];
                        pat_nz[i]    = nz_reg[i + 1];
                    end
                    pat_strip[NUM_PIXELS-1] = '0;
                    pat_nz[NUM_PIXELS-1]    = 1'b0;
                    pat_done = ~|nz_reg[NUM_PIXELS-1:1];
                end
            end
            PAT_OVERHEAT:
            begin
                for (int i = 0; i < NUM_PIXELS; i++)
                begin
                    if (((i % 2) == 1) != off)
                    begin
                        pat_strip[i] = color_reg;
                        pat_nz[i]    = lit_nz;
                    end
                    else
                    begin
                        pat_strip[i] = '0;
                        pat_nz[i]    = 1'b0;
                    end
                end
            end
            PAT_STARTUP:
            begin
                if (step_reg > LAST_POS || drop_reg > LAST_POS)
                begin
                    sp = '0;
                    dp = '0;
                end
                if (first_reg)
                begin
                    pat_strip = '{default: '0};
                    pat_nz    = '0;
                    pat_strip[NUM_PIXELS-1] = color_reg;
                    pat_nz[NUM_PIXELS-1]    = lit_nz;
                    pat_step  = LAST_POS;
                    pat_drop  = POS_W'(1);
                end
                else
                begin
                    if (dp == '0)
                    begin
                        pat_strip[NUM_PIXELS-1] = color_reg;
                        pat_nz[NUM_PIXELS-1]    = lit_nz;
                        pat_done = (sp == '0);
                    end
                    else
                    begin
                        below_idx = PIX_IDX_W'(LAST_POS - dp);
                        above_idx = PIX_IDX_W'(PN_POS - dp);
                        moved     = strip_reg[above_idx];
                        moved_nz  = nz_reg[above_idx];
                        for (int i = 0; i < NUM_PIXELS; i++)
                        begin
                            if (i == int'(below_idx))
                            begin
                                pat_strip[i] = moved;
                                pat_nz[i]    = moved_nz;
                            end
                            if (i == int'(above_idx))
                            begin
                                pat_strip[i] = '0;
                                pat_nz[i]    = 1'b0;
                            end
                        end
                    end
                    drop_inc = dp + 1'b1;
                    if (drop_inc > sp)
                    begin
                        pat_drop = '0;
                        pat_step = (sp != '0) ? sp - 1'b1 : '0;
                    end
                    else
                    begin
                        pat_drop = drop_inc;
                        pat_step = sp;
                    end
                end
            end
            default:
            begin
                pat_done = 1'b0;
            end
        endcase
    end

    // outcome of the command word
    always_comb
    begin
        acc_sum       = acc_reg + TICK_AMOUNT;
        interval      = (interval_reg < MIN_INTERVAL) ? ACC_W'(MIN_INTERVAL)
                                                      : ACC_W'(interval_reg);
        strip_exec    = strip_reg;
        nz_exec       = nz_reg;
        step_next     = step_reg;
        drop_next     = drop_reg;
        acc_next      = acc_reg;
        steps_next    = steps_reg;
        first_next    = first_reg;
        running_next  = running_reg;
        finished_next = 1'b0;
        emit_frame    = 1'b0;
        run_pat       = 1'b0;
        timed         = 1'b0;
        case (lbps_op_t'(operation))
            OP_START:
            begin
                running_next = 1'b1;
                first_next   = 1'b1;
                acc_next     = '0;
                steps_next   = limit_reg;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                if (clear_on_stop)
                begin
                    emit_frame = 1'b1;
                    strip_exec = '{default: '0};
                    nz_exec    = '0;
                end
            end
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (first_reg)
                    begin
                        run_pat    = 1'b1;
                        first_next = 1'b0;
                        acc_next   = '0;
                    end
                    else if (acc_sum >= interval)
                    begin
                        run_pat  = 1'b1;
                        timed    = 1'b1;
                        acc_next = acc_sum - interval;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
            end
            default:
            begin
                emit_frame = 1'b0;
            end
        endcase
        if (run_pat)
        begin
            emit_frame = 1'b1;
            strip_exec = pat_strip;
            nz_exec    = pat_nz;
            step_next  = pat_step;
            drop_next  = pat_drop;
            if (pat_done)
            begin
                running_next  = 1'b0;
                finished_next = 1'b1;
            end
        end
        if (timed && steps_reg != '0)
        begin
            steps_next = steps_reg - 1'b1;
            if (steps_reg == LIMIT_W'(1))
            begin
                running_next  = 1'b0;
                finished_next = 1'b1;
            end
        end
    end

    // strip: load on a command, rotate by one per streamed word
    always_comb
    begin
        strip_next = strip_reg;
        nz_next    = nz_reg;
        if (ctl.exec)
        begin
            strip_next = strip_exec;
            nz_next    = nz_exec;
        end
        else if (ctl.advance)
        begin
            for (int i = 0; i < NUM_PIXELS; i++)
            begin
                strip_next[i] = strip_reg[(i + 1) % NUM_PIXELS];
                nz_next[i]    = nz_reg[(i + 1) % NUM_PIXELS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg       <= '{default: '0};
            nz_reg          <= '0;
            step_reg        <= '0;
            drop_reg        <= '0;
            acc_reg         <= '0;
            steps_reg       <= '0;
            first_reg       <= 1'b0;
            running_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            frame_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            strip_reg <= strip_next;
            nz_reg    <= nz_next;
            if (ctl.exec)
            begin
                step_reg        <= step_next;
                drop_reg        <= drop_next;
                acc_reg         <= acc_next;
                steps_reg       <= steps_next;
                first_reg       <= first_next;
                running_reg     <= running_next;
                finished_reg    <= finished_next;
                frame_valid_reg <= emit_frame;
                idx_reg         <= '0;
            end
            else if (ctl.advance)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    assign frame_valid      = frame_valid_reg;
    assign pixel_index      = IDX_OUT_W'(idx_reg);
    assign pixel_word       = frame_valid_reg ? strip_reg[0] : '0;
    assign last_pixel       = !frame_valid_reg || (idx_reg == LAST_IDX);
    assign is_running       = running_reg;
    assign pattern_finished = finished_reg;

    assign stat.emit_frame  = emit_frame;
    assign stat.last_pixel  = last_pixel;

    `LBPS_ASSERT(a_advance_in_frame, clk, rst_n, ctl.advance |-> frame_valid_reg, "advance outside a frame")
    `LBPS_ASSERT_ALWAYS(a_finished_stopped, clk, finished_reg |-> !running_reg, "finished while running")
    `LBPS_ASSERT(a_step_range, clk, rst_n, step_reg <= PN_POS, "step position out of range")
endmodule
`default_nettype wire

/* hw/rtl/lbps_controller.sv */
// Controller: command acceptance and result streaming state machine
`default_nettype none
`include "assert_macros.svh"
module lbps_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lbps_pkg::lbps_stat_t stat,
    output lbps_pkg::lbps_ctl_t  ctl
);
    import lbps_pkg::*;

    lbps_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        ctl.exec    = 1'b0;
        ctl.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.exec   = 1'b1;
                    state_next = stat.emit_frame ? ST_FRAME : ST_STATUS;
                end
            end
            ST_FRAME:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctl.advance = 1'b1;
                    if (stat.last_pixel)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LBPS_ASSERT(a_frame_ends, clk, rst_n, (state_reg == ST_FRAME && out_ready && stat.last_pixel) |=> (state_reg == ST_IDLE), "frame did not end after last word")
    `LBPS_ASSERT(a_status_holds, clk, rst_n, (state_reg == ST_STATUS && !out_ready) |=> (state_reg == ST_STATUS), "status word dropped")
    `LBPS_ASSERT(a_exec_busy, clk, rst_n, ctl.exec |=> (state_reg != ST_IDLE), "command gave no result")
endmodule
`default_nettype wire

/* hw/rtl/led_bar_pattern_sequencer.sv */
// LED bar pattern sequencer: the first result word follows in the cycle after the
// command word is accepted. A frame streams NUM_PIXELS words, one per cycle while the
// sink is ready, out of a rotating strip register; a status update is a single word.
// A new command is accepted only once the last result word of the one before is taken.
// Reset (rst_n, async low) clears the strip, positions and flags, sets the
// step interval to 1024 and all other configuration registers to zero.
`default_nettype none
module led_bar_pattern_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    lbps_cmd_if.sink                          cmd,
    lbps_pix_if.source                        pix,
    input  logic                              cfg_write,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lbps_pkg::*;

    lbps_ctl_t  ctl;
    lbps_stat_t stat;

    lbps_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (pix.valid),
        .out_ready (pix.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    lbps_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .operation        (cmd.operation),
        .clear_on_stop    (cmd.clear_on_stop),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .frame_valid      (pix.frame_valid),
        .pixel_index      (pix.pixel_index),
        .pixel_word       (pix.pixel_word),
        .last_pixel       (pix.last_pixel),
        .is_running       (pix.is_running),
        .pattern_finished (pix.pattern_finished)
    );
endmodule
`default_nettype wire
